[rtl/core/aks_pkg.sv]
// Shared types, constants and the ASCII to HID usage map for the keystroke report sequencer.
`default_nettype none

package aks_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned CODE_W          = 8;
    localparam int unsigned TICK_W          = 9;

    localparam logic [CODE_W-1:0] HOLD_RESET = 8'd15;
    localparam logic [TICK_W-1:0] TICK_MAX   = 9'h1FF;

    localparam logic FUNC_PUSH   = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [CODE_W-1:0] KEY_NONE    = 8'h00;
    localparam logic [CODE_W-1:0] KEY_A       = 8'h04;
    localparam logic [CODE_W-1:0] KEY_1       = 8'h1E;
    localparam logic [CODE_W-1:0] KEY_0       = 8'h27;
    localparam logic [CODE_W-1:0] KEY_NEWLINE = 8'h28;

    localparam logic [CODE_W-1:0] ASCII_LF = 8'h0A;
    localparam logic [CODE_W-1:0] ASCII_0  = 8'h30;
    localparam logic [CODE_W-1:0] ASCII_1  = 8'h31;
    localparam logic [CODE_W-1:0] ASCII_9  = 8'h39;
    localparam logic [CODE_W-1:0] ASCII_LA = 8'h61;
    localparam logic [CODE_W-1:0] ASCII_LZ = 8'h7A;

    // One decoded word passed from the front to the back.
    typedef struct packed {
        logic              is_tick;
        logic [CODE_W-1:0] code;
    } t_cmd;

    // One result word.
    typedef struct packed {
        logic              kind;
        logic              accepted;
        logic [CODE_W-1:0] keycode;
    } t_result;

    function automatic logic [CODE_W-1:0] map_key(input logic [CODE_W-1:0] c);
        logic [CODE_W-1:0] key;
        key = KEY_NONE;
        if (c >= ASCII_LA && c <= ASCII_LZ) begin
            key = KEY_A + (c - ASCII_LA);
        end else if (c >= ASCII_1 && c <= ASCII_9) begin
            key = KEY_1 + (c - ASCII_1);
        end else if (c == ASCII_0) begin
            key = KEY_0;
        end else if (c == ASCII_LF) begin
            key = KEY_NEWLINE;
        end
        return key;
    endfunction

endpackage

`default_nettype wire

[rtl/core/aks_front.sv]
// Front end: accept input words, decode them and hold them in a two-entry command queue.
`default_nettype none

module aks_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_func,
    input  wire logic [aks_pkg::CODE_W-1:0]    i_char_code,
    output logic                               o_cmd_valid,
    output aks_pkg::t_cmd                      o_cmd,
    input  wire logic                          i_cmd_pop
);

    aks_pkg::t_cmd r_q [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          n_wr;
    logic          n_rd;
    logic [1:0]    n_cnt;
    logic          push;
    logic          pop;
    aks_pkg::t_cmd dec;

    always_comb begin
        dec.is_tick = (i_func == aks_pkg::FUNC_TICK);
        dec.code    = i_char_code;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_wr  = push ? ~r_wr : r_wr;
        n_rd  = pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= dec;
        end
    end

endmodule

`default_nettype wire

[rtl/core/aks_back.sv]
// Back end: character FIFO, press/release sequencer and the output register.
`default_nettype none

module aks_back #(
    parameter int unsigned QUEUE_DEPTH = aks_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [aks_pkg::CODE_W-1:0]    i_cfg_wdata,
    input  wire logic                          i_cmd_valid,
    input  wire aks_pkg::t_cmd                 i_cmd,
    output logic                               o_cmd_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output aks_pkg::t_result                   o_result
);

    localparam int unsigned ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_CNT  = FILL_W'(QUEUE_DEPTH);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PRESS   = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    logic [aks_pkg::CODE_W-1:0] r_mem [QUEUE_DEPTH];
    logic [aks_pkg::CODE_W-1:0] r_rd_data;
    logic [aks_pkg::CODE_W-1:0] r_hold;
    logic [ADDR_W-1:0]          r_head, n_head;
    logic [ADDR_W-1:0]          r_tail, n_tail;
    logic [FILL_W-1:0]          r_fill, n_fill;
    logic [1:0]                 r_phase, n_phase;
    logic [aks_pkg::TICK_W-1:0] r_elapsed, n_elapsed;
    logic [aks_pkg::TICK_W-1:0] el_inc;
    logic                       r_out_valid, n_out_valid;
    aks_pkg::t_result           r_out;
    aks_pkg::t_result           res;
    logic                       res_valid;
    logic                       fire;
    logic                       wr_en;
    logic                       hold_done;

    assign fire      = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_cmd_pop = fire;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    assign el_inc    = (r_elapsed == aks_pkg::TICK_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign hold_done = (el_inc > {1'b0, r_hold});

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        wr_en     = 1'b0;
        res_valid = 1'b0;
        res       = '0;
        if (fire) begin
            if (!i_cmd.is_tick) begin
                res_valid = 1'b1;
                res.kind  = aks_pkg::KIND_ACK;
                if (r_fill != FULL_CNT) begin
                    wr_en        = 1'b1;
                    n_tail       = (r_tail == LAST_ADDR) ? '0 : r_tail + 1'b1;
                    n_fill       = r_fill + 1'b1;
                    res.accepted = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_PRESS: begin
                        if (hold_done) begin
                            n_elapsed = '0;
                            n_phase   = PH_RELEASE;
                            res_valid = 1'b1;
                            res.kind  = aks_pkg::KIND_REPORT;
                        end else begin
                            n_elapsed = el_inc;
                        end
                    end
                    PH_RELEASE: begin
                        if (hold_done) begin
                            n_elapsed = '0;
                            n_phase   = PH_IDLE;
                        end else begin
                            n_elapsed = el_inc;
                        end
                    end
                    default: begin
                        // Idle, and the unused code behaves the same.
                        n_phase = PH_IDLE;
                        if (r_fill != '0) begin
                            n_head      = (r_head == LAST_ADDR) ? '0 : r_head + 1'b1;
                            n_fill      = r_fill - 1'b1;
                            n_elapsed   = '0;
                            n_phase     = PH_PRESS;
                            res_valid   = 1'b1;
                            res.kind    = aks_pkg::KIND_REPORT;
                            res.keycode = aks_pkg::map_key(r_rd_data);
                        end
                    end
                endcase
            end
        end
        n_out_valid = (fire && res_valid) ? 1'b1 : (i_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= aks_pkg::HOLD_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_phase     <= PH_IDLE;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hold <= i_cfg_wdata;
            end
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out <= res;
        end
    end

    // Prefetch the next head entry; forward a write that lands on it.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_tail] <= i_cmd.code;
        end
        if (wr_en && (r_tail == n_head)) begin
            r_rd_data <= i_cmd.code;
        end else begin
            r_rd_data <= r_mem[n_head];
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count exceeds queue depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_head == r_tail))
        else $error("empty queue with unequal pointers");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result was dropped or overwritten");

    a_press_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_cmd.is_tick && r_phase == PH_IDLE && r_fill != '0)
            |=> (r_phase == PH_PRESS && r_elapsed == '0))
        else $error("dequeue did not enter press phase");
`endif

endmodule

`default_nettype wire

[rtl/core/ascii_keystroke_report_sequencer.sv]
// An accepted word is registered in the command queue, its result word, if any, in the output register.
// Throughput: one word per cycle; the back end retires one command per cycle unless the output is stalled.
// A result stalled on i_ready holds the back end; the input keeps taking words
// until the two-entry command queue is full, then drops o_ready.
// Reset (i_rst_n low, synchronous): queues empty, sequencer idle, hold_ticks = 15.
// FIFO storage is not cleared; entries are only read after being written.
`default_nettype none

module ascii_keystroke_report_sequencer #(
    parameter int unsigned QUEUE_DEPTH = aks_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration: hold_ticks
    input  wire logic                          i_cfg_we,
    input  wire logic [aks_pkg::CODE_W-1:0]    i_cfg_wdata,
    // input word channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_func,
    input  wire logic [aks_pkg::CODE_W-1:0]    i_char_code,
    // result word channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_kind,
    output logic                               o_accepted,
    output logic [aks_pkg::CODE_W-1:0]         o_keycode
);

    aks_pkg::t_cmd    cmd;
    aks_pkg::t_result result;
    logic             cmd_valid;
    logic             cmd_pop;

    // Front: take every word the command queue has room for and decode it
    // into push or tick. Two entries keep the input flowing back to back,
    // since o_ready does not wait on the pop from the back end.
    aks_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_char_code (i_char_code),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: execute commands strictly in order. A push updates the
    // character FIFO and answers with an acknowledge; a tick advances the
    // press/release sequencer and may dequeue a byte into a press report.
    // A command retires whenever the output register is free or draining.
    aks_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (result)
    );

    // Split the result word onto its ports.
    assign o_kind     = result.kind;
    assign o_accepted = result.accepted;
    assign o_keycode  = result.keycode;

endmodule

`default_nettype wire
